[sv/range_address_translation_unit_macros.svh]
// ---------------------------------------------------------------------------
// Range address translation unit: assertion macros
// Shorthand for the clocked checks used in the top level.
// ---------------------------------------------------------------------------
`ifndef RANGE_ADDRESS_TRANSLATION_UNIT_MACROS_SVH
`define RANGE_ADDRESS_TRANSLATION_UNIT_MACROS_SVH

// same-cycle implication, clk / rst_n of the enclosing module
`define RATU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RATU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ratu_pkg.sv]
// ---------------------------------------------------------------------------
// ratu_pkg
// Shared constants, codes and types of the range address translation unit.
// ---------------------------------------------------------------------------
package ratu_pkg;

  localparam int ENTRY_COUNT_DEF  = 16;
  localparam int ADDRESS_BITS_DEF = 40;
  localparam int ENTRY_INDEX_W    = 4;
  localparam int LENGTH_W         = 8;
  localparam int CFG_INDEX_W      = 2;

  localparam logic [63:0] LOCAL_START_RST = 64'h0000_0000_C000_0000;
  localparam logic [63:0] LOCAL_SIZE_RST  = 64'h0000_0000_0080_0000;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_WRITE  = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TRANSLATION_ENABLE = 2'd0,
    CFG_LOCAL_REGION_START = 2'd1,
    CFG_LOCAL_REGION_SIZE  = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic xlate_hit;  // some valid entry holds the address
    logic check_hit;  // some valid entry holds the whole checked span
  } ratu_match_t;

endpackage

[sv/ratu_intf.sv]
// ---------------------------------------------------------------------------
// ratu channel interfaces
// Valid/ready channels for lookup/write items, results and register writes.
// ---------------------------------------------------------------------------
interface ratu_in_if import ratu_pkg::*; #(
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) ();
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [ADDRESS_BITS-1:0]  address;
  logic [LENGTH_W-1:0]      length_minus_one;
  logic [ENTRY_INDEX_W-1:0] entry_index;
  logic                     entry_valid;
  logic [ADDRESS_BITS-1:0]  entry_phys_base;
  logic [ADDRESS_BITS-1:0]  entry_range_start;
  logic [ADDRESS_BITS-1:0]  entry_range_end;

  modport source (
    output valid, kind, address, length_minus_one, entry_index, entry_valid,
           entry_phys_base, entry_range_start, entry_range_end,
    input  ready
  );
  modport sink (
    input  valid, kind, address, length_minus_one, entry_index, entry_valid,
           entry_phys_base, entry_range_start, entry_range_end,
    output ready
  );
endinterface

interface ratu_out_if import ratu_pkg::*; #(
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) ();
  logic                    valid;
  logic                    ready;
  logic [ADDRESS_BITS-1:0] phys_address;
  logic                    translate_valid;
  logic                    access_ok;

  modport source (output valid, phys_address, translate_valid, access_ok, input ready);
  modport sink   (input valid, phys_address, translate_valid, access_ok, output ready);
endinterface

interface ratu_cfg_if import ratu_pkg::*; #(
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) ();
  logic                    valid;
  logic                    ready;
  logic [CFG_INDEX_W-1:0]  index;
  logic [ADDRESS_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/range_address_translation_unit.sv]
// ---------------------------------------------------------------------------
// range_address_translation_unit
// Range-based address translation with access check and entry write port.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  - one transaction per item: a lookup (kind 0: address, length - 1)
//            or a write of one table entry (kind 1: index, valid, base, range).
//   out_ch - exactly one result transaction per input item, in order. A write
//            answers with all fields zero.
//   cfg_ch - register writes (enable, local region start, local region size);
//            always ready, only to be used while the block is idle.
// Path: the input register, then compare, select and translate in one pass
//   into the result register.
// Throughput: 1 item per cycle while out_ch is ready; set by the single
//   combinational pass between the input register and the result register.
// Reset (rst_n low, synchronous): all entries invalid, translation disabled,
//   local region back to its default, both registers empty.
// Stall: when out_ch is not ready the result register holds; the input
//   register still takes one more item, so two items are held before
//   in_ch.ready drops.
// Entry writes take effect for every item accepted after them.
// ---------------------------------------------------------------------------
`include "range_address_translation_unit_macros.svh"

module range_address_translation_unit import ratu_pkg::*; #(
  parameter int ENTRY_COUNT  = ENTRY_COUNT_DEF,
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ratu_in_if.sink   in_ch,
  ratu_out_if.source out_ch,
  ratu_cfg_if.sink  cfg_ch
);

  localparam int AW = ADDRESS_BITS;

  // ---------------- configuration registers ----------------
  logic          xlate_en_r;
  logic [AW-1:0] local_start_r;
  logic [AW-1:0] local_size_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xlate_en_r    <= 1'b0;
      local_start_r <= AW'(LOCAL_START_RST);
      local_size_r  <= AW'(LOCAL_SIZE_RST);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_TRANSLATION_ENABLE: xlate_en_r    <= cfg_ch.data[0];
        CFG_LOCAL_REGION_START: local_start_r <= cfg_ch.data;
        CFG_LOCAL_REGION_SIZE:  local_size_r  <= cfg_ch.data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic s1_v_r, out_v_r;
  logic out_en, s1_en;

  assign out_en      = !out_v_r || out_ch.ready;
  assign s1_en       = !s1_v_r || out_en;
  assign in_ch.ready = s1_en;

  // ---------------- input register ----------------
  logic                     s1_kind_r;
  logic [AW-1:0]            s1_addr_r;
  logic [LENGTH_W-1:0]      s1_lm1_r;
  logic [ENTRY_INDEX_W-1:0] s1_idx_r;
  logic                     s1_ev_r;
  logic [AW-1:0]            s1_base_r;
  logic [AW-1:0]            s1_start_r;
  logic [AW-1:0]            s1_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_en) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_ch.valid) begin
      s1_kind_r  <= in_ch.kind;
      s1_addr_r  <= in_ch.address;
      s1_lm1_r   <= in_ch.length_minus_one;
      s1_idx_r   <= in_ch.entry_index;
      s1_ev_r    <= in_ch.entry_valid;
      s1_base_r  <= in_ch.entry_phys_base;
      s1_start_r <= in_ch.entry_range_start;
      s1_end_r   <= in_ch.entry_range_end;
    end
  end

  // local region tests; ends carry one extra bit so they never wrap
  logic [AW:0] local_lo_w, local_end_w, addr_w, chk_end_w;
  logic        local_start, local_end_in, local_ok;

  assign local_lo_w   = {1'b0, local_start_r};
  assign local_end_w  = {1'b0, local_start_r} + {1'b0, local_size_r};
  assign addr_w       = {1'b0, s1_addr_r};
  assign chk_end_w    = addr_w + (AW+1)'(s1_lm1_r);
  assign local_start  = (addr_w >= local_lo_w) && (addr_w < local_end_w);
  assign local_end_in = (chk_end_w >= local_lo_w) && (chk_end_w < local_end_w);
  assign local_ok     = local_start && local_end_in;

  // entry writes commit as the write item leaves the input register
  logic          tbl_wr_en;
  ratu_match_t   match;
  logic [AW-1:0] sel_start, sel_base;

  assign tbl_wr_en = s1_v_r && out_en && (s1_kind_r == KIND_WRITE);

  ratu_entry_table #(
    .ENTRY_COUNT  (ENTRY_COUNT),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_table (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr_en        (tbl_wr_en),
    .wr_index     (s1_idx_r),
    .wr_valid     (s1_ev_r),
    .wr_base      (s1_base_r),
    .wr_start     (s1_start_r),
    .wr_end       (s1_end_r),
    .lk_addr      (s1_addr_r),
    .lk_use_alt   (local_start),
    .lk_alt_start (local_end_w),
    .lk_chk_end   (chk_end_w),
    .lk_match     (match),
    .lk_sel_start (sel_start),
    .lk_sel_base  (sel_base)
  );

  // translate and pick the result
  logic [AW-1:0] phys_nxt;
  logic          tvalid_nxt, ok_nxt;

  always_comb begin
    phys_nxt   = '0;
    tvalid_nxt = 1'b0;
    ok_nxt     = 1'b0;
    if (s1_kind_r == KIND_LOOKUP) begin
      if (!xlate_en_r) begin
        phys_nxt   = s1_addr_r;
        tvalid_nxt = 1'b1;
        ok_nxt     = 1'b1;
      end else begin
        ok_nxt = local_ok || match.check_hit;
        if (local_start) begin
          phys_nxt   = s1_addr_r;
          tvalid_nxt = 1'b1;
        end else if (match.xlate_hit) begin
          phys_nxt   = s1_addr_r - sel_start + sel_base;  // wraps mod 2^AW
          tvalid_nxt = 1'b1;
        end
      end
    end
  end

  // ---------------- result register ----------------
  logic [AW-1:0] phys_r;
  logic          tvalid_r, ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_en) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s1_v_r) begin
      phys_r   <= phys_nxt;
      tvalid_r <= tvalid_nxt;
      ok_r     <= ok_nxt;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.phys_address    = phys_r;
  assign out_ch.translate_valid = tvalid_r;
  assign out_ch.access_ok       = ok_r;

  // ---------------- assertions ----------------
  `RATU_ASSERT_NEXT(a_accept_fills_s1, in_ch.valid && in_ch.ready, s1_v_r, "accepted item lost")
  `RATU_ASSERT_NOW(a_miss_is_zero, out_v_r && !tvalid_r, phys_r == '0, "miss carries an address")
  `RATU_ASSERT_NEXT(a_write_zero, s1_v_r && out_en && (s1_kind_r == KIND_WRITE), out_v_r && !tvalid_r && !ok_r && phys_r == '0, "write result not zero")
  `RATU_ASSERT_NEXT(a_local_valid, s1_v_r && out_en && (s1_kind_r == KIND_LOOKUP) && local_start, out_v_r && tvalid_r, "local not passed")

endmodule

[sv/ratu_entry_table.sv]
// ---------------------------------------------------------------------------
// ratu_entry_table
// Translation entries with one comparator lane per entry and first-hit select.
// ---------------------------------------------------------------------------
module ratu_entry_table import ratu_pkg::*; #(
  parameter int ENTRY_COUNT  = ENTRY_COUNT_DEF,
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // entry write
  input  logic                     wr_en,
  input  logic [ENTRY_INDEX_W-1:0] wr_index,
  input  logic                     wr_valid,
  input  logic [ADDRESS_BITS-1:0]  wr_base,
  input  logic [ADDRESS_BITS-1:0]  wr_start,
  input  logic [ADDRESS_BITS-1:0]  wr_end,
  // lookup
  input  logic [ADDRESS_BITS-1:0]  lk_addr,
  input  logic                     lk_use_alt,   // check span starts at local end
  input  logic [ADDRESS_BITS:0]    lk_alt_start, // local region end, with carry
  input  logic [ADDRESS_BITS:0]    lk_chk_end,   // addr + length - 1, with carry
  output ratu_match_t              lk_match,
  output logic [ADDRESS_BITS-1:0]  lk_sel_start,
  output logic [ADDRESS_BITS-1:0]  lk_sel_base
);

  logic [ENTRY_COUNT-1:0]  valid_r;
  logic [ADDRESS_BITS-1:0] base_r  [ENTRY_COUNT];
  logic [ADDRESS_BITS-1:0] start_r [ENTRY_COUNT];
  logic [ADDRESS_BITS-1:0] end_r   [ENTRY_COUNT];

  logic [ENTRY_COUNT-1:0]  lane_we;
  logic [ENTRY_COUNT-1:0]  xl_hit;
  logic [ENTRY_COUNT-1:0]  chk_hit;
  logic [ENTRY_COUNT-1:0]  first_hit;

  for (genvar i = 0; i < ENTRY_COUNT; i++) begin : g_lane
    localparam logic [ENTRY_INDEX_W:0] LANE_ID = (ENTRY_INDEX_W+1)'(i);
    logic lo_ok;

    assign lane_we[i] = wr_en && ({1'b0, wr_index} == LANE_ID);

    always_ff @(posedge clk) begin
      if (lane_we[i]) begin
        base_r[i]  <= wr_base;
        start_r[i] <= wr_start;
        end_r[i]   <= wr_end;
      end
    end

    assign xl_hit[i] = valid_r[i] && (lk_addr >= start_r[i]) && (lk_addr < end_r[i]);
    assign lo_ok     = lk_use_alt ? (lk_alt_start >= {1'b0, start_r[i]})
                                  : (lk_addr >= start_r[i]);
    assign chk_hit[i] = valid_r[i] && lo_ok && (lk_chk_end < {1'b0, end_r[i]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        if (lane_we[i]) valid_r[i] <= wr_valid;
      end
    end
  end

  // lowest-numbered hit wins
  assign first_hit = xl_hit & (~xl_hit + ENTRY_COUNT'(1));

  always_comb begin
    lk_sel_start = '0;
    lk_sel_base  = '0;
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      lk_sel_start |= {ADDRESS_BITS{first_hit[i]}} & start_r[i];
      lk_sel_base  |= {ADDRESS_BITS{first_hit[i]}} & base_r[i];
    end
  end

  assign lk_match.xlate_hit = |xl_hit;
  assign lk_match.check_hit = |chk_hit;

endmodule

[tb/tb_range_address_translation_unit.sv]
// ---------------------------------------------------------------------------
// tb_range_address_translation_unit
// Self-checking bench for the range address translation unit. A queue-fed
// driver sends lookup and entry-write transactions, a clocked monitor predicts
// every result from its own copy of the table and registers, and checks the
// result stream field by field. Register settings change between phases,
// with random idling on both channels.
// ---------------------------------------------------------------------------
module tb_range_address_translation_unit;
  import ratu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AW             = ADDRESS_BITS_DEF;
  localparam int NE             = ENTRY_COUNT_DEF;
  localparam int RAND_PHASES    = 8;
  localparam int ITEMS_PER_PH   = 150;
  localparam int SETTLE_CYCLES  = 8;     // two registers deep, leave margin
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all

  // one input transaction, lookup or entry write
  typedef struct packed {
    logic                     kind;
    logic [AW-1:0]            address;
    logic [LENGTH_W-1:0]      len_m1;
    logic [ENTRY_INDEX_W-1:0] idx;
    logic                     ent_valid;
    logic [AW-1:0]            base;
    logic [AW-1:0]            rstart;
    logic [AW-1:0]            rend;
  } ratu_item_t;

  // one result transaction
  typedef struct packed {
    logic [AW-1:0] phys;
    logic          hit;
    logic          ok;
  } xlate_result_t;

  logic clk;
  logic rst_n;

  ratu_in_if  in_ch ();
  ratu_out_if out_ch ();
  ratu_cfg_if cfg_ch ();

  range_address_translation_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // -------------------------------------------------------------------------
  // Bench state
  // -------------------------------------------------------------------------
  ratu_item_t    pending_q[$];       // items waiting for the driver
  xlate_result_t expected_xlate_q[$]; // predicted results, oldest first

  int queued_cnt;    // items handed to the driver
  int accepted_cnt;  // input transactions seen by the monitor
  int mismatches;
  int idle_cycles;
  int send_idle_pct;
  int recv_stall_pct;
  logic in_taken;    // input transaction completed at the last rising edge

  // predictor copy of registers and table
  logic          xl_en;
  logic [AW-1:0] loc_start;
  logic [AW-1:0] loc_size;
  logic          ent_vld   [NE];
  logic [AW-1:0] ent_base  [NE];
  logic [AW-1:0] ent_start [NE];
  logic [AW-1:0] ent_end   [NE];

  // generator's view of the table, used only to aim lookups at entries
  logic          gen_vld   [NE];
  logic [AW-1:0] gen_start [NE];
  logic [AW-1:0] gen_end   [NE];

  // coverage tallies for the summary
  int n_lookups, n_writes, n_entry_hits, n_local_hits, n_ok, n_settings;

  // -------------------------------------------------------------------------
  // Clock
  // -------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Predictor: applies an entry write, or works out the translated address,
  // the translate-valid flag and the access check of a lookup. Ends of spans
  // are kept one bit wider so they never wrap.
  // -------------------------------------------------------------------------
  function automatic xlate_result_t translate_item(ratu_item_t it);
    xlate_result_t r;
    logic [AW:0]   a_w, loc_lo, loc_hi, chk_lo, chk_hi;
    logic          loc_hit;
    int            i;
    r = '0;
    if (it.kind == KIND_WRITE) begin
      // all indexes of a 4-bit field exist in a 16-entry table
      ent_vld[it.idx]   = it.ent_valid;
      ent_base[it.idx]  = it.base;
      ent_start[it.idx] = it.rstart;
      ent_end[it.idx]   = it.rend;
      n_writes++;
      return r;
    end
    n_lookups++;
    if (!xl_en) begin
      // disabled: pass through, always permitted
      r.phys = it.address;
      r.hit  = 1'b1;
      r.ok   = 1'b1;
      n_ok++;
      return r;
    end
    a_w     = {1'b0, it.address};
    loc_lo  = {1'b0, loc_start};
    loc_hi  = {1'b0, loc_start} + {1'b0, loc_size};
    loc_hit = (a_w >= loc_lo) && (a_w < loc_hi);
    if (loc_hit) begin
      r.phys = it.address;
      r.hit  = 1'b1;
      n_local_hits++;
    end else begin
      // lowest-numbered matching entry wins; sum wraps at AW bits
      for (i = 0; i < NE; i++) begin
        if (ent_vld[i] && it.address >= ent_start[i] && it.address < ent_end[i]) begin
          r.phys = it.address - ent_start[i] + ent_base[i];
          r.hit  = 1'b1;
          n_entry_hits++;
          break;
        end
      end
    end
    chk_lo = a_w;
    chk_hi = a_w + (AW+1)'(it.len_m1);
    if (loc_hit) begin
      // runs past the local region: the remainder must fit one entry
      if (chk_hi >= loc_lo && chk_hi < loc_hi) r.ok = 1'b1;
      else chk_lo = loc_hi;
    end
    if (!r.ok) begin
      // any valid entry may cover the span, not just the translating one
      for (i = 0; i < NE; i++) begin
        if (ent_vld[i] && chk_lo >= {1'b0, ent_start[i]} && chk_hi < {1'b0, ent_end[i]}) begin
          r.ok = 1'b1;
          break;
        end
      end
    end
    if (r.ok) n_ok++;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  function automatic logic [AW-1:0] rand_addr();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[AW-1:0];
  endfunction

  // address within a few hundred bytes of a pivot, wrapping at the top
  function automatic logic [AW-1:0] jitter(logic [AW-1:0] pivot);
    logic [AW-1:0] off;
    off = AW'($urandom_range(600));
    return pivot + off - AW'(300);
  endfunction

  // unused fields carry random junk so every bit toggles
  task automatic push_lookup(logic [AW-1:0] addr, logic [LENGTH_W-1:0] len_m1);
    ratu_item_t it;
    it.kind      = KIND_LOOKUP;
    it.address   = addr;
    it.len_m1    = len_m1;
    it.idx       = ENTRY_INDEX_W'($urandom_range(NE - 1));
    it.ent_valid = 1'($urandom_range(1));
    it.base      = rand_addr();
    it.rstart    = rand_addr();
    it.rend      = rand_addr();
    pending_q.insert(pending_q.size(), it);
    queued_cnt++;
  endtask

  task automatic push_entry(int idx, logic vld, logic [AW-1:0] base,
                            logic [AW-1:0] rstart, logic [AW-1:0] rend);
    ratu_item_t it;
    it.kind      = KIND_WRITE;
    it.address   = rand_addr();
    it.len_m1    = LENGTH_W'($urandom_range(255));
    it.idx       = ENTRY_INDEX_W'(idx);
    it.ent_valid = vld;
    it.base      = base;
    it.rstart    = rstart;
    it.rend      = rend;
    gen_vld[idx]   = vld;
    gen_start[idx] = rstart;
    gen_end[idx]   = rend;
    pending_q.insert(pending_q.size(), it);
    queued_cnt++;
  endtask

  // register write transaction; only issued while nothing is in flight
  task automatic reg_write(cfg_index_t idx, logic [AW-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_regs(logic en, logic [AW-1:0] lstart, logic [AW-1:0] lsize);
    reg_write(CFG_TRANSLATION_ENABLE, AW'(en));
    reg_write(CFG_LOCAL_REGION_START, lstart);
    reg_write(CFG_LOCAL_REGION_SIZE, lsize);
    n_settings++;
  endtask

  // sender holds off until every result is back and the block is empty
  task automatic wait_drained();
    while (accepted_cnt != queued_cnt || expected_xlate_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // Driver: new item at the falling edge once the previous one is taken
  // -------------------------------------------------------------------------
  always @(negedge clk) begin : drive_in
    ratu_item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_q.pop_front();
        in_ch.valid             <= 1'b1;
        in_ch.kind              <= nxt.kind;
        in_ch.address           <= nxt.address;
        in_ch.length_minus_one  <= nxt.len_m1;
        in_ch.entry_index       <= nxt.idx;
        in_ch.entry_valid       <= nxt.ent_valid;
        in_ch.entry_phys_base   <= nxt.base;
        in_ch.entry_range_start <= nxt.rstart;
        in_ch.entry_range_end   <= nxt.rend;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // -------------------------------------------------------------------------
  // Monitor: predicts on input transactions, tracks register writes, checks
  // result transactions, and runs the watchdog.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    ratu_item_t    seen;
    xlate_result_t want;
    int            i;
    if (!rst_n) begin
      in_taken    <= 1'b0;
      idle_cycles <= 0;
      xl_en       = 1'b0;
      loc_start   = LOCAL_START_RST[AW-1:0];
      loc_size    = LOCAL_SIZE_RST[AW-1:0];
      for (i = 0; i < NE; i++) ent_vld[i] = 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;

      if (in_ch.valid && in_ch.ready) begin
        seen.kind      = in_ch.kind;
        seen.address   = in_ch.address;
        seen.len_m1    = in_ch.length_minus_one;
        seen.idx       = in_ch.entry_index;
        seen.ent_valid = in_ch.entry_valid;
        seen.base      = in_ch.entry_phys_base;
        seen.rstart    = in_ch.entry_range_start;
        seen.rend      = in_ch.entry_range_end;
        expected_xlate_q.insert(expected_xlate_q.size(), translate_item(seen));
        accepted_cnt++;
      end

      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_index_t'(cfg_ch.index))
          CFG_TRANSLATION_ENABLE: xl_en     = cfg_ch.data[0];
          CFG_LOCAL_REGION_START: loc_start = cfg_ch.data;
          CFG_LOCAL_REGION_SIZE:  loc_size  = cfg_ch.data;
          default: ;
        endcase
      end

      if (out_ch.valid && out_ch.ready) begin
        if (expected_xlate_q.size() == 0) begin
          $display("%0t: unexpected result phys_address %h translate_valid %b access_ok %b",
                   $time, out_ch.phys_address, out_ch.translate_valid, out_ch.access_ok);
          mismatches++;
        end else begin
          want = expected_xlate_q.pop_front();
          if (out_ch.phys_address !== want.phys) begin
            $display("%0t: phys_address expected %h actual %h",
                     $time, want.phys, out_ch.phys_address);
            mismatches++;
          end
          if (out_ch.translate_valid !== want.hit) begin
            $display("%0t: translate_valid expected %b actual %b",
                     $time, want.hit, out_ch.translate_valid);
            mismatches++;
          end
          if (out_ch.access_ok !== want.ok) begin
            $display("%0t: access_ok expected %b actual %b",
                     $time, want.ok, out_ch.access_ok);
            mismatches++;
          end
        end
      end

      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, expected_xlate_q.size());
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin : stimulus
    int            ph, n, k, j;
    logic [AW-1:0] a, s, t;
    logic [LENGTH_W-1:0] len;
    logic          en;

    // every input known from time zero
    rst_n                   = 1'b0;
    in_ch.valid             = 1'b0;
    in_ch.kind              = KIND_LOOKUP;
    in_ch.address           = '0;
    in_ch.length_minus_one  = '0;
    in_ch.entry_index       = '0;
    in_ch.entry_valid       = 1'b0;
    in_ch.entry_phys_base   = '0;
    in_ch.entry_range_start = '0;
    in_ch.entry_range_end   = '0;
    out_ch.ready            = 1'b0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.index            = CFG_TRANSLATION_ENABLE;
    cfg_ch.data             = '0;
    send_idle_pct           = 0;
    recv_stall_pct          = 0;
    for (k = 0; k < NE; k++) gen_vld[k] = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed, reset settings (translation off) ---
    // entry 0 sits right after the default local region
    push_entry(0, 1'b1, 40'h00_1234_0000, 40'h00_C080_0000, 40'h00_C081_0000);
    // entry 1: base near the top so the translated sum wraps
    push_entry(1, 1'b1, 40'hFF_FFFF_F800, 40'h00_0000_1000, 40'h00_0000_2000);
    // entry 2 overlaps entry 1
    push_entry(2, 1'b1, 40'h00_0000_8000, 40'h00_0000_1800, 40'h00_0000_3000);
    // entry 3: end before start, never matches
    push_entry(3, 1'b1, 40'h00_0000_0055, 40'h00_0000_5000, 40'h00_0000_4000);
    // entry 4 runs up to the last address, which its exclusive end leaves out
    push_entry(4, 1'b1, '0, 40'hFF_FFFF_FF00, '1);
    push_entry(15, 1'b0, '1, '1, '1);
    push_lookup('1, 8'hFF);
    push_lookup('0, 8'h00);
    push_lookup(40'h00_0000_1800, 8'h10);
    wait_drained();

    // --- directed, translation on with default local region ---
    set_regs(1'b1, LOCAL_START_RST[AW-1:0], LOCAL_SIZE_RST[AW-1:0]);
    push_lookup(40'h00_C000_0000, 8'h00);   // first local byte
    push_lookup(40'h00_BFFF_FFFF, 8'h00);   // just below local, no entry
    push_lookup(40'h00_C07F_FFF0, 8'h3F);   // leaves local, tail in entry 0
    push_lookup(40'h00_C07F_FFF0, 8'h0F);   // wholly local
    push_lookup(40'h00_0000_1F80, 8'hFF);   // wraps; check met by entry 2 only
    push_lookup(40'h00_0000_1900, 8'h00);   // overlap, lowest index wins
    push_lookup(40'h00_0000_4800, 8'h00);   // inside reversed entry 3
    push_lookup(40'hFF_FFFF_FFF0, 8'hFF);   // span end carries past the top
    push_lookup(40'hFF_FFFF_FF00, 8'hFE);   // fits entry 4 exactly
    push_lookup(40'h00_0000_2FFF, 8'h00);   // last byte of entry 2
    push_lookup(40'h00_0000_3000, 8'h00);   // exclusive end of entry 2
    push_entry(2, 1'b0, '0, 40'h00_0000_1800, 40'h00_0000_3000);  // clear
    push_lookup(40'h00_0000_2800, 8'h00);
    wait_drained();

    // --- random phases, each with its own register setting ---
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      en = 1'b1;
      case (ph)
        0: begin s = LOCAL_START_RST[AW-1:0]; t = LOCAL_SIZE_RST[AW-1:0]; end
        1: begin s = '0;                     t = '0; end        // empty region
        2: begin s = '1;                     t = '1; end        // end carries
        3: begin s = '0;                     t = '1; end        // nearly all local
        4: begin s = rand_addr(); t = rand_addr(); en = 1'b0; end
        5: begin s = rand_addr(); t = AW'($urandom_range(1, 65536)); end
        6: begin s = rand_addr(); t = rand_addr(); end
        default: begin s = 40'hFF_FFFF_0000; t = 40'h00_0001_0000; end  // ends at top
      endcase
      set_regs(en, s, t);

      // idling mix rotates: none, sender, receiver, both
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase

      for (n = 0; n < ITEMS_PER_PH; n++) begin
        if ($urandom_range(99) < 20) begin
          // entry write: ranges placed around interesting addresses
          case ($urandom_range(3))
            0: s = rand_addr();
            1: s = jitter(loc_start);
            2: s = jitter(loc_start + loc_size);
            default: s = '1 - AW'($urandom_range(4096));
          endcase
          case ($urandom_range(4))
            0: t = rand_addr();
            1: t = s;                                   // empty range
            2: t = s - AW'($urandom_range(1, 256));     // end before start
            default: t = s + AW'($urandom_range(1, 4096));
          endcase
          push_entry($urandom_range(NE - 1), $urandom_range(3) != 0, rand_addr(), s, t);
        end else begin
          case ($urandom_range(5))
            0: a = rand_addr();
            1, 2: begin
              // aim at the edges of some valid entry
              k = $urandom_range(NE - 1);
              for (j = 0; j < NE && !gen_vld[k]; j++) k = (k + 1) % NE;
              if (!gen_vld[k]) a = rand_addr();
              else if ($urandom_range(1)) a = jitter(gen_start[k]);
              else a = jitter(gen_end[k]);
            end
            3: a = jitter(loc_start);
            4: a = jitter(loc_start + loc_size);
            default: a = '1 - AW'($urandom_range(300));
          endcase
          case ($urandom_range(3))
            0: len = '0;
            1: len = '1;
            default: len = LENGTH_W'($urandom_range(255));
          endcase
          push_lookup(a, len);
        end
      end
      wait_drained();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_drained();

    $display("Ran %0d lookups (%0d by entry, %0d local, %0d access ok) and %0d entry writes",
             n_lookups, n_entry_hits, n_local_hits, n_ok, n_writes);
    $display("across %0d register settings with sender and receiver idling mixes",
             n_settings);
    if (expected_xlate_q.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, expected_xlate_q.size());
    if (mismatches == 0 && expected_xlate_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/ratu_pkg.sv
sv/ratu_intf.sv
sv/ratu_entry_table.sv
sv/range_address_translation_unit.sv
tb/tb_range_address_translation_unit.sv
